// File: rtl/core/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg: shared types and constants of the 4x4 column multiplier
// Widths, operation codes and the transaction record passed along the chain.
// ----------------------------------------------------------------------------
package mcm_pkg;

  localparam int unsigned LANES         = 4;
  localparam int unsigned COL_W         = 2;
  localparam int unsigned ELEM_W        = 32;
  localparam int unsigned PROD_W        = 2 * ELEM_W;
  // Four full products need two extra bits to stay exact.
  localparam int unsigned SUM_W         = PROD_W + 2;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_MUL  = 1'b1;

  typedef struct packed {
    logic                             mode;
    logic [COL_W-1:0]                 column;
    logic [LANES-1:0][ELEM_W-1:0]     elem;
    logic [LANES-1:0][SUM_W-1:0]      sum;
  } mcm_item_t;

  // Signed 32 x 32 product, full 64-bit result.
  function automatic logic signed [PROD_W-1:0] mul_full(
    input logic signed [ELEM_W-1:0] a,
    input logic signed [ELEM_W-1:0] b
  );
    mul_full = a * b;
  endfunction

endpackage

// File: rtl/core/mcm_cell.sv
// ----------------------------------------------------------------------------
// mcm_cell: one cell of the multiply chain
// Holds one left-matrix column, multiplies it by its input element and adds
// the four products to the running row sums of the passing transaction.
// ----------------------------------------------------------------------------
module mcm_cell
  import mcm_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  mcm_item_t in_item,
  output logic      out_vld,
  output mcm_item_t out_item
);

  logic [LANES-1:0][ELEM_W-1:0] col_r, col_nxt;
  logic                         s1_vld_r;
  mcm_item_t                    s1_item_r;
  logic [LANES-1:0][PROD_W-1:0] s1_prod_r, s1_prod_nxt;
  logic                         s2_vld_r;
  mcm_item_t                    s2_item_r, s2_item_nxt;
  logic                         load_hit;

  // A load writes this column as it passes, so earlier multiplies in the
  // chain have already read the old value and later ones see the new one.
  assign load_hit = in_vld && (in_item.mode == MODE_LOAD) &&
                    (in_item.column == IDX[COL_W-1:0]);

  always_comb begin
    col_nxt     = load_hit ? in_item.elem : col_r;
    s2_item_nxt = s1_item_r;
    for (int r = 0; r < LANES; r++) begin
      s1_prod_nxt[r]     = mul_full($signed(col_r[r]), $signed(in_item.elem[IDX]));
      s2_item_nxt.sum[r] = s1_item_r.sum[r] + SUM_W'($signed(s1_prod_r[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      col_r    <= col_nxt;
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= in_item;
      s1_prod_r <= s1_prod_nxt;
      s2_item_r <= s2_item_nxt;
    end
  end

  assign out_vld  = s2_vld_r;
  assign out_item = s2_item_r;

endmodule

// File: rtl/core/mcm_out.sv
// ----------------------------------------------------------------------------
// mcm_out: scaling, saturation and output register
// Drops the fraction bits of the exact sums, clamps to 32 bits and holds
// the result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module mcm_out
  import mcm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  mcm_item_t                    in_item,
  output logic                         out_vld,
  output logic [COL_W-1:0]             out_col,
  output logic [LANES-1:0][ELEM_W-1:0] out_prod,
  output logic                         out_sat
);

  logic                         vld_r, vld_nxt;
  logic [COL_W-1:0]             col_r;
  logic [LANES-1:0][ELEM_W-1:0] prod_r, prod_nxt;
  logic                         sat_r, sat_nxt;
  logic [LANES-1:0][SUM_W-1:0]  shifted;
  logic [LANES-1:0]             lane_sat;

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      shifted[r] = $signed(in_item.sum[r]) >>> FRAC_BITS;
      // Fits when every bit above the result's sign bit matches it.
      lane_sat[r] = !((&shifted[r][SUM_W-1:ELEM_W-1]) ||
                      !(|shifted[r][SUM_W-1:ELEM_W-1]));
      if (!lane_sat[r]) begin
        prod_nxt[r] = shifted[r][ELEM_W-1:0];
      end else if (in_item.sum[r][SUM_W-1]) begin
        prod_nxt[r] = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
        prod_nxt[r] = {1'b0, {(ELEM_W-1){1'b1}}};
      end
    end
    sat_nxt = |lane_sat;
    vld_nxt = en ? (in_vld && (in_item.mode == MODE_MUL)) : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r  <= in_item.column;
      prod_r <= prod_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_col  = col_r;
  assign out_prod = prod_r;
  assign out_sat  = sat_r;

endmodule

// File: rtl/core/matrix4_column_multiply.sv
// ----------------------------------------------------------------------------
// matrix4_column_multiply: 4x4 column-major matrix product, signed fixed point
// Holds the left matrix in a chain of four cells and multiplies streamed
// right-matrix columns by it, one column per transaction.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Carries
//   -------  ---------------------  ----------------------------------------
//   input    in_valid / in_ready    in_mode, in_column, in_elem_0..3
//   result   out_valid / out_ready  out_column, out_prod_0..3, out_saturated
//
// One transaction is accepted per cycle unless the output stalls. A multiply
// transaction passes two register stages in each of the four cells (product,
// then accumulate) and then the output register, which also does the scaling
// and saturation, before its result column appears.
// A load transaction travels down the same chain and writes its column into
// the matching cell as it passes, so loads and multiplies keep their order.
// Loads produce no result transaction.
// While a result waits at the output unaccepted, the whole chain holds and
// in_ready is low; an empty output register never stalls the input.
// Reset clears the left matrix to zero and empties the chain.
//
module matrix4_column_multiply
  import mcm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [COL_W-1:0]         in_column,
  input  logic signed [ELEM_W-1:0] in_elem_0,
  input  logic signed [ELEM_W-1:0] in_elem_1,
  input  logic signed [ELEM_W-1:0] in_elem_2,
  input  logic signed [ELEM_W-1:0] in_elem_3,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COL_W-1:0]         out_column,
  output logic signed [ELEM_W-1:0] out_prod_0,
  output logic signed [ELEM_W-1:0] out_prod_1,
  output logic signed [ELEM_W-1:0] out_prod_2,
  output logic signed [ELEM_W-1:0] out_prod_3,
  output logic                     out_saturated
);

  // Chain links: link 0 is the input, link LANES feeds the output stage.
  logic                         link_vld  [LANES+1];
  mcm_item_t                    link_item [LANES+1];
  logic                         en;
  logic [LANES-1:0][ELEM_W-1:0] prod;

  // The chain advances whenever the output register is empty or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // The incoming transaction enters the chain with zeroed row sums.
  always_comb begin
    link_vld[0]         = in_valid;
    link_item[0].mode   = in_mode;
    link_item[0].column = in_column;
    link_item[0].elem   = {in_elem_3, in_elem_2, in_elem_1, in_elem_0};
    link_item[0].sum    = '0;
  end

  // Cell k holds left-matrix column k and adds column k times elem_k.
  for (genvar g = 0; g < LANES; g++) begin : g_cell
    mcm_cell #(
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (link_vld[g]),
      .in_item  (link_item[g]),
      .out_vld  (link_vld[g+1]),
      .out_item (link_item[g+1])
    );
  end

  mcm_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (link_vld[LANES]),
    .in_item  (link_item[LANES]),
    .out_vld  (out_valid),
    .out_col  (out_column),
    .out_prod (prod),
    .out_sat  (out_saturated)
  );

  assign out_prod_0 = prod[0];
  assign out_prod_1 = prod[1];
  assign out_prod_2 = prod[2];
  assign out_prod_3 = prod[3];

endmodule

// File: rtl/core/mcm_chk.sv
// ----------------------------------------------------------------------------
// mcm_chk: port-level checks of the 4x4 column multiplier
// Watches the handshakes and result flags; bound to the top level.
// ----------------------------------------------------------------------------
module mcm_chk
  import mcm_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [COL_W-1:0]         out_column,
  input logic signed [ELEM_W-1:0] out_prod_0,
  input logic signed [ELEM_W-1:0] out_prod_1,
  input logic signed [ELEM_W-1:0] out_prod_2,
  input logic signed [ELEM_W-1:0] out_prod_3,
  input logic                     out_saturated
);

  localparam logic [ELEM_W-1:0] S_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] S_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // A result transaction that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column) &&
      $stable(out_prod_0) && $stable(out_prod_1) && $stable(out_prod_2) &&
      $stable(out_prod_3) && $stable(out_saturated))
    else $error("result transaction changed while stalled");

  // A held result blocks new input transactions.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // An empty output never stalls the input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A saturated result shows at least one clamped element.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_prod_0 == S_MAX) || (out_prod_0 == S_MIN) ||
      (out_prod_1 == S_MAX) || (out_prod_1 == S_MIN) ||
      (out_prod_2 == S_MAX) || (out_prod_2 == S_MIN) ||
      (out_prod_3 == S_MAX) || (out_prod_3 == S_MIN))
    else $error("saturation flag without a clamped element");

endmodule

bind matrix4_column_multiply mcm_chk u_mcm_chk (.*);
